[rtl/pdd_pkg.sv]
// Shared constants, types and helpers of the projective dependency decoder.
`timescale 1ns / 1ps
package pdd_pkg;

  localparam int MAX_WORDS   = 64;
  localparam int WORD_W      = 6;
  localparam int MAX_LABELS  = 16;
  localparam int LABEL_W     = 4;
  localparam int LCOUNT_W    = 5;
  localparam int LEN_W       = 7;
  localparam int SCORE_W     = 32;
  localparam int ACC_W       = 40;
  localparam int CELL_AW     = 2 * WORD_W;
  localparam int LCELL_AW    = 2 * WORD_W + LABEL_W;
  localparam int STACK_DEPTH = 2 * MAX_WORDS;
  localparam int STACK_AW    = 7;
  localparam int SP_W        = 8;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int HEAD_W      = 7;
  localparam int WLABEL_W    = 5;

  localparam logic [OP_W-1:0] OP_LOAD_UNL = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_LAB = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_USE_UNL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_LAB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAB_OUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAB_COUNT = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic signed [ACC_W-1:0]  score;
    logic [WORD_W-1:0]        split;
    logic [LABEL_W-1:0]       label;
  } cmp_entry_t;

  typedef struct packed {
    logic                     valid;
    logic signed [ACC_W-1:0]  score;
    logic [WORD_W-1:0]        split;
  } inc_entry_t;

  typedef struct packed {
    logic                inc;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    logic [LABEL_W-1:0]  lab;
  } frame_t;

  typedef struct packed {
    logic [WORD_W-1:0]   head;
    logic [LABEL_W-1:0]  label;
  } word_entry_t;

  function automatic logic signed [ACC_W-1:0] sext_score(input logic [SCORE_W-1:0] v);
    sext_score = {{(ACC_W - SCORE_W){v[SCORE_W-1]}}, v};
  endfunction

endpackage

[rtl/projective_dependency_decoder_core.sv]
// Top level: first-order projective dependency decoder with span tables in RAM.
//
// Score loads (operation 0 and 1) may be issued back to back; busy stays low. A
// decode item of nonzero length raises busy until its last result is out. Decode
// time is set by the single read port of the span RAMs: for each span, every
// incomplete cell is built one label and direction at a time, every complete cell
// one split and label at a time, with L labels in use; the backtrace passes
// S_TP, S_TF, S_TD, S_TU1 and S_TU2 for each stack frame, and results follow
// through S_O and S_OW, n results for a length of n up to MAX_WORDS. Results
// carry out_valid for one cycle and cannot be held off. No clearing pass after
// reset: every span cell a decode reads was written earlier in the same decode.
`timescale 1ns / 1ps
module projective_dependency_decoder_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [pdd_pkg::OP_W-1:0]               in_operation,
  input  logic [pdd_pkg::WORD_W-1:0]             in_head,
  input  logic [pdd_pkg::WORD_W-1:0]             in_dependent,
  input  logic [pdd_pkg::LABEL_W-1:0]            in_label,
  input  logic signed [pdd_pkg::SCORE_W-1:0]     in_score,
  input  logic [pdd_pkg::LEN_W-1:0]              in_length,
  output logic                                   out_valid,
  output logic [pdd_pkg::WORD_W-1:0]             out_word,
  output logic signed [pdd_pkg::HEAD_W-1:0]      out_head_word,
  output logic signed [pdd_pkg::WLABEL_W-1:0]    out_word_label,
  output logic                                   out_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pdd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pdd_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import pdd_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] S_FA_ARC  = 5'd1;
  localparam logic [ST_W-1:0] S_FA_ARCW = 5'd2;
  localparam logic [ST_W-1:0] S_FA_R0   = 5'd3;
  localparam logic [ST_W-1:0] S_FA_R1   = 5'd4;
  localparam logic [ST_W-1:0] S_FA_R2   = 5'd5;
  localparam logic [ST_W-1:0] S_FA_WR   = 5'd6;
  localparam logic [ST_W-1:0] S_FB_P    = 5'd7;
  localparam logic [ST_W-1:0] S_FB_PW   = 5'd8;
  localparam logic [ST_W-1:0] S_FB_I    = 5'd9;
  localparam logic [ST_W-1:0] S_FB_IW   = 5'd10;
  localparam logic [ST_W-1:0] S_FB_WR   = 5'd11;
  localparam logic [ST_W-1:0] S_T0      = 5'd12;
  localparam logic [ST_W-1:0] S_T1      = 5'd13;
  localparam logic [ST_W-1:0] S_TP      = 5'd14;
  localparam logic [ST_W-1:0] S_TF      = 5'd15;
  localparam logic [ST_W-1:0] S_TD      = 5'd16;
  localparam logic [ST_W-1:0] S_TU1     = 5'd17;
  localparam logic [ST_W-1:0] S_TU2     = 5'd18;
  localparam logic [ST_W-1:0] S_O       = 5'd19;
  localparam logic [ST_W-1:0] S_OW      = 5'd20;

  // configuration
  logic                 use_unl_r, use_lab_r, lab_out_r;
  logic [LCOUNT_W-1:0]  lab_count_r;

  // control
  logic [ST_W-1:0]      state_r, state_nxt;
  logic [LEN_W-1:0]     n_r, n_nxt;
  logic [LCOUNT_W-1:0]  nl_r, nl_nxt;
  logic [WORD_W-1:0]    w_r, w_nxt, s_r, s_nxt, r_r, r_nxt, k_r, k_nxt;
  logic [LABEL_W-1:0]   l_r, l_nxt;
  logic                 dir_r, dir_nxt;
  logic [SP_W-1:0]      sp_r, sp_nxt;
  logic [MAX_WORDS-1:0] hv_r, hv_nxt;

  // datapath
  logic signed [ACC_W-1:0] best_r, best_nxt, arc_r, arc_nxt, opa_r, opa_nxt;
  logic                    bvalid_r, bvalid_nxt, vala_r, vala_nxt;
  logic [WORD_W-1:0]       bsplit_r, bsplit_nxt;
  logic [LABEL_W-1:0]      blab_r, blab_nxt;
  frame_t                  f_r, f_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic                    p1_en_r, p1_en_nxt, p2_en_r, p2_en_nxt;

  logic                    out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [WORD_W-1:0]       out_word_r, out_word_nxt;
  logic [HEAD_W-1:0]       out_head_r, out_head_nxt;
  logic [WLABEL_W-1:0]     out_label_r, out_label_nxt;

  // RAM ports
  logic                 unl_we, lab_we, cmp_we, inc_we, stk_we, wrd_we;
  logic [CELL_AW-1:0]   unl_waddr, unl_raddr, cmp_waddr, cmp_raddr;
  logic [LCELL_AW-1:0]  lab_waddr, lab_raddr, inc_waddr, inc_raddr;
  logic [STACK_AW-1:0]  stk_waddr, stk_raddr;
  logic [WORD_W-1:0]    wrd_waddr, wrd_raddr;
  logic [SCORE_W-1:0]   unl_q, lab_q;
  cmp_entry_t           cmp_wdata, cmp_q;
  inc_entry_t           inc_wdata, inc_q;
  frame_t               stk_wdata, stk_q;
  word_entry_t          wrd_wdata, wrd_q;

  logic                 accept, load_unl, load_lab;
  logic [WORD_W-1:0]    t_w, nm1, r_inc;
  logic [LABEL_W-1:0]   nl_m1;
  logic [LEN_W-1:0]     len_sat;
  logic                 a_diag, b_diag, p_diag, b_last_r;
  logic signed [ACC_W-1:0] sum_ab, cand_b;
  word_entry_t          cur_word;

  assign accept   = start && !busy;
  assign load_unl = accept && (in_operation == OP_LOAD_UNL);
  assign load_lab = accept && (in_operation == OP_LOAD_LAB);
  assign busy     = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign t_w   = s_r + w_r;
  assign nm1   = WORD_W'(n_r - LEN_W'(1));
  assign r_inc = r_r + WORD_W'(1);
  assign nl_m1 = LABEL_W'(nl_r - LCOUNT_W'(1));
  assign len_sat = (in_length > LEN_W'(MAX_WORDS)) ? LEN_W'(MAX_WORDS) : in_length;

  assign a_diag   = (r_r == s_r);
  assign b_diag   = (r_inc == t_w);
  assign p_diag   = dir_r ? (r_r == s_r) : (r_r == t_w);
  assign b_last_r = dir_r ? (r_inc == t_w) : (r_r == t_w);

  always_comb begin
    logic signed [ACC_W-1:0] opb;
    opb    = b_diag ? '0 : cmp_q.score;
    sum_ab = opa_r + opb;
    cand_b = inc_q.score + opa_r;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_unl_r   <= 1'b1;
      use_lab_r   <= 1'b0;
      lab_out_r   <= 1'b0;
      lab_count_r <= LCOUNT_W'(MAX_LABELS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_USE_UNL:   use_unl_r   <= cfg_data[0];
        REG_USE_LAB:   use_lab_r   <= cfg_data[0];
        REG_LAB_OUT:   lab_out_r   <= cfg_data[0];
        REG_LAB_COUNT: lab_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // RAM addresses, write enables and write data
  always_comb begin
    unl_raddr = dir_r ? {t_w, s_r} : {s_r, t_w};
    lab_raddr = dir_r ? {t_w, s_r, l_r} : {s_r, t_w, l_r};
    cmp_raddr = '0;
    case (state_r)
      S_FA_R0: cmp_raddr = {s_r, r_r};
      S_FA_R1: cmp_raddr = {t_w, r_inc};
      S_FB_P:  cmp_raddr = dir_r ? {r_r, s_r} : {r_r, t_w};
      S_T0:    cmp_raddr = {WORD_W'(0), nm1};
      S_TF:    cmp_raddr = {stk_q.a, stk_q.b};
      default: cmp_raddr = '0;
    endcase
    inc_raddr = (state_r == S_TF) ? {stk_q.a, stk_q.b, stk_q.lab}
                                  : (dir_r ? {t_w, r_r, l_r} : {s_r, r_r, l_r});
    stk_raddr = STACK_AW'(sp_r - SP_W'(1));
    wrd_raddr = k_r;

    unl_we    = load_unl;
    unl_waddr = {in_head, in_dependent};
    lab_we    = load_lab;
    lab_waddr = {in_head, in_dependent, in_label};

    inc_we    = (state_r == S_FA_WR);
    inc_waddr = dir_r ? {t_w, s_r, l_r} : {s_r, t_w, l_r};
    inc_wdata = '{valid: bvalid_r, score: best_r + arc_r, split: bsplit_r};

    cmp_we    = (state_r == S_FB_WR);
    cmp_waddr = dir_r ? {t_w, s_r} : {s_r, t_w};
    cmp_wdata = '{valid: bvalid_r, score: best_r, split: bsplit_r, label: blab_r};

    stk_we    = 1'b0;
    stk_wdata = p1_r;
    case (state_r)
      S_T1: begin
        stk_we    = cmp_q.valid;
        stk_wdata = '{inc: 1'b0, a: '0, b: nm1, lab: '0};
      end
      S_TU1: begin
        stk_we    = p1_en_r && (sp_r < SP_W'(STACK_DEPTH));
        stk_wdata = p1_r;
      end
      S_TU2: begin
        stk_we    = p2_en_r && (sp_r < SP_W'(STACK_DEPTH));
        stk_wdata = p2_r;
      end
      default: ;
    endcase
    stk_waddr = STACK_AW'(sp_r);

    wrd_we    = (state_r == S_TD) && f_r.inc;
    wrd_waddr = f_r.b;
    wrd_wdata = '{head: f_r.a, label: f_r.lab};
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    nl_nxt     = nl_r;
    w_nxt      = w_r;
    s_nxt      = s_r;
    r_nxt      = r_r;
    k_nxt      = k_r;
    l_nxt      = l_r;
    dir_nxt    = dir_r;
    sp_nxt     = sp_r;
    hv_nxt     = hv_r;
    best_nxt   = best_r;
    arc_nxt    = arc_r;
    opa_nxt    = opa_r;
    bvalid_nxt = bvalid_r;
    vala_nxt   = vala_r;
    bsplit_nxt = bsplit_r;
    blab_nxt   = blab_r;
    f_nxt      = f_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    p1_en_nxt  = p1_en_r;
    p2_en_nxt  = p2_en_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_word_nxt  = out_word_r;
    out_head_nxt  = out_head_r;
    out_label_nxt = out_label_r;
    cur_word      = wrd_q;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_operation == OP_DECODE) && (len_sat != '0)) begin
          n_nxt   = len_sat;
          if (lab_count_r == '0) begin
            nl_nxt = LCOUNT_W'(1);
          end else if (lab_count_r > LCOUNT_W'(MAX_LABELS)) begin
            nl_nxt = LCOUNT_W'(MAX_LABELS);
          end else begin
            nl_nxt = lab_count_r;
          end
          hv_nxt  = '0;
          w_nxt   = WORD_W'(1);
          s_nxt   = '0;
          l_nxt   = '0;
          dir_nxt = 1'b0;
          k_nxt   = '0;
          state_nxt = (len_sat < LEN_W'(2)) ? S_O : S_FA_ARC;
        end
      end

      // incomplete cells: one label and direction at a time
      S_FA_ARC: state_nxt = S_FA_ARCW;
      S_FA_ARCW: begin
        arc_nxt = (use_unl_r ? sext_score(unl_q) : '0)
                + (use_lab_r ? sext_score(lab_q) : '0);
        bvalid_nxt = 1'b0;
        r_nxt      = s_r;
        state_nxt  = S_FA_R0;
      end
      S_FA_R0: state_nxt = S_FA_R1;
      S_FA_R1: begin
        vala_nxt  = a_diag ? 1'b1 : cmp_q.valid;
        opa_nxt   = a_diag ? '0 : cmp_q.score;
        state_nxt = S_FA_R2;
      end
      S_FA_R2: begin
        if (vala_r && (b_diag || cmp_q.valid)) begin
          if (!bvalid_r || (sum_ab > best_r)) begin
            bvalid_nxt = 1'b1;
            best_nxt   = sum_ab;
            bsplit_nxt = r_r;
          end
        end
        if (b_diag) begin
          state_nxt = S_FA_WR;
        end else begin
          r_nxt     = r_inc;
          state_nxt = S_FA_R0;
        end
      end
      S_FA_WR: begin
        if (l_r == nl_m1) begin
          l_nxt = '0;
          if (!dir_r && (s_r != '0)) begin
            dir_nxt   = 1'b1;
            state_nxt = S_FA_ARC;
          end else begin
            dir_nxt    = 1'b0;
            bvalid_nxt = 1'b0;
            r_nxt      = s_r + WORD_W'(1);
            state_nxt  = S_FB_P;
          end
        end else begin
          l_nxt     = l_r + LABEL_W'(1);
          state_nxt = S_FA_ARC;
        end
      end

      // complete cells
      S_FB_P: state_nxt = S_FB_PW;
      S_FB_PW: begin
        opa_nxt = p_diag ? '0 : cmp_q.score;
        l_nxt   = '0;
        if (p_diag || cmp_q.valid) begin
          state_nxt = S_FB_I;
        end else if (b_last_r) begin
          state_nxt = S_FB_WR;
        end else begin
          r_nxt     = r_inc;
          state_nxt = S_FB_P;
        end
      end
      S_FB_I: state_nxt = S_FB_IW;
      S_FB_IW: begin
        if (inc_q.valid && (!bvalid_r || (cand_b > best_r))) begin
          bvalid_nxt = 1'b1;
          best_nxt   = cand_b;
          bsplit_nxt = r_r;
          blab_nxt   = l_r;
        end
        if (l_r != nl_m1) begin
          l_nxt     = l_r + LABEL_W'(1);
          state_nxt = S_FB_I;
        end else if (b_last_r) begin
          state_nxt = S_FB_WR;
        end else begin
          r_nxt     = r_inc;
          state_nxt = S_FB_P;
        end
      end
      S_FB_WR: begin
        bvalid_nxt = 1'b0;
        l_nxt      = '0;
        if (!dir_r && (s_r != '0)) begin
          dir_nxt   = 1'b1;
          r_nxt     = s_r;
          state_nxt = S_FB_P;
        end else begin
          dir_nxt = 1'b0;
          if (t_w == nm1) begin
            if (w_r == nm1) begin
              state_nxt = S_T0;
            end else begin
              w_nxt     = w_r + WORD_W'(1);
              s_nxt     = '0;
              state_nxt = S_FA_ARC;
            end
          end else begin
            s_nxt     = s_r + WORD_W'(1);
            state_nxt = S_FA_ARC;
          end
        end
      end

      // backtrace
      S_T0: state_nxt = S_T1;
      S_T1: begin
        if (cmp_q.valid) begin
          sp_nxt    = SP_W'(1);
          state_nxt = S_TP;
        end else begin
          sp_nxt    = '0;
          state_nxt = S_O;
        end
      end
      S_TP: begin
        if (sp_r == '0) begin
          state_nxt = S_O;
        end else begin
          sp_nxt    = sp_r - SP_W'(1);
          state_nxt = S_TF;
        end
      end
      S_TF: begin
        f_nxt     = stk_q;
        state_nxt = S_TD;
      end
      S_TD: begin
        if (f_r.inc) begin
          hv_nxt[f_r.b] = 1'b1;
          if (f_r.a < f_r.b) begin
            p1_nxt    = '{inc: 1'b0, a: f_r.a, b: inc_q.split, lab: '0};
            p1_en_nxt = (f_r.a != inc_q.split);
            p2_nxt    = '{inc: 1'b0, a: f_r.b, b: inc_q.split + WORD_W'(1), lab: '0};
            p2_en_nxt = (f_r.b != inc_q.split + WORD_W'(1));
          end else begin
            p1_nxt    = '{inc: 1'b0, a: f_r.b, b: inc_q.split, lab: '0};
            p1_en_nxt = (f_r.b != inc_q.split);
            p2_nxt    = '{inc: 1'b0, a: f_r.a, b: inc_q.split + WORD_W'(1), lab: '0};
            p2_en_nxt = (f_r.a != inc_q.split + WORD_W'(1));
          end
        end else begin
          p1_nxt    = '{inc: 1'b1, a: f_r.a, b: cmp_q.split, lab: cmp_q.label};
          p1_en_nxt = 1'b1;
          p2_nxt    = '{inc: 1'b0, a: cmp_q.split, b: f_r.b, lab: '0};
          p2_en_nxt = (cmp_q.split != f_r.b);
        end
        state_nxt = S_TU1;
      end
      S_TU1: begin
        if (stk_we) begin
          sp_nxt = sp_r + SP_W'(1);
        end
        state_nxt = S_TU2;
      end
      S_TU2: begin
        if (stk_we) begin
          sp_nxt = sp_r + SP_W'(1);
        end
        state_nxt = S_TP;
      end

      // results, one word per pass through S_O and S_OW
      S_O: state_nxt = S_OW;
      S_OW: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = k_r;
        out_last_nxt  = (k_r == nm1);
        out_head_nxt  = hv_r[k_r] ? {1'b0, cur_word.head} : '1;
        out_label_nxt = (hv_r[k_r] && lab_out_r) ? {1'b0, cur_word.label} : '1;
        if (k_r == nm1) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + WORD_W'(1);
          state_nxt = S_O;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      hv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sp_r        <= sp_nxt;
      hv_r        <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    nl_r     <= nl_nxt;
    w_r      <= w_nxt;
    s_r      <= s_nxt;
    r_r      <= r_nxt;
    k_r      <= k_nxt;
    l_r      <= l_nxt;
    dir_r    <= dir_nxt;
    best_r   <= best_nxt;
    arc_r    <= arc_nxt;
    opa_r    <= opa_nxt;
    bvalid_r <= bvalid_nxt;
    vala_r   <= vala_nxt;
    bsplit_r <= bsplit_nxt;
    blab_r   <= blab_nxt;
    f_r      <= f_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    p1_en_r  <= p1_en_nxt;
    p2_en_r  <= p2_en_nxt;
    out_last_r  <= out_last_nxt;
    out_word_r  <= out_word_nxt;
    out_head_r  <= out_head_nxt;
    out_label_r <= out_label_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_head_word  = $signed(out_head_r);
  assign out_word_label = $signed(out_label_r);
  assign out_last       = out_last_r;

  pdd_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_WORDS * MAX_WORDS)) u_unl_ram (
    .clk(clk), .we(unl_we), .waddr(unl_waddr), .wdata(in_score),
    .raddr(unl_raddr), .rdata(unl_q)
  );

  pdd_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_WORDS * MAX_WORDS * MAX_LABELS)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(in_score),
    .raddr(lab_raddr), .rdata(lab_q)
  );

  pdd_ram #(.WIDTH($bits(cmp_entry_t)), .DEPTH(MAX_WORDS * MAX_WORDS)) u_cmp_ram (
    .clk(clk), .we(cmp_we), .waddr(cmp_waddr), .wdata(cmp_wdata),
    .raddr(cmp_raddr), .rdata(cmp_q)
  );

  pdd_ram #(.WIDTH($bits(inc_entry_t)), .DEPTH(MAX_WORDS * MAX_WORDS * MAX_LABELS)) u_inc_ram (
    .clk(clk), .we(inc_we), .waddr(inc_waddr), .wdata(inc_wdata),
    .raddr(inc_raddr), .rdata(inc_q)
  );

  pdd_ram #(.WIDTH($bits(frame_t)), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q)
  );

  pdd_ram #(.WIDTH($bits(word_entry_t)), .DEPTH(MAX_WORDS)) u_wrd_ram (
    .clk(clk), .we(wrd_we), .waddr(wrd_waddr), .wdata(wrd_wdata),
    .raddr(wrd_raddr), .rdata(wrd_q)
  );

endmodule

[rtl/pdd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pdd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pdd_chk.sv]
// Port-level checker for the decoder core, bound to the top level.
`timescale 1ns / 1ps
module pdd_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [pdd_pkg::OP_W-1:0]            in_operation,
  input logic [pdd_pkg::LEN_W-1:0]           in_length,
  input logic                                out_valid,
  input logic [pdd_pkg::WORD_W-1:0]          out_word,
  input logic signed [pdd_pkg::HEAD_W-1:0]   out_head_word,
  input logic signed [pdd_pkg::WLABEL_W-1:0] out_word_label,
  input logic                                out_last
);
  import pdd_pkg::*;

  // loads leave the core idle
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_LOAD_UNL || in_operation == OP_LOAD_LAB))
    |=> !busy) else $error("load left the core busy");

  a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_DECODE && in_length != '0) |=> busy)
    else $error("decode did not raise busy");

  // more results still to come keep the core busy
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy) else $error("idle before last item");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word == '0) |-> (out_head_word == -7'sd1))
    else $error("root item has a head");

  a_root_label: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_head_word == -7'sd1) |-> (out_word_label == -5'sd1))
    else $error("headless item carries a label");

endmodule

bind projective_dependency_decoder_core pdd_chk u_pdd_chk (.*);

[verif/tb.sv]
// Testbench for the projective dependency decoder core: directed table, two configured decodes, then random sentences.
`timescale 1ns / 1ps
module tb;
  import pdd_pkg::*;

  localparam int LIMIT  = 20000000;
  localparam int SETTLE = 16;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0]          word;
    logic signed [HEAD_W-1:0]   head;
    logic signed [WLABEL_W-1:0] lab;
    logic                       last;
  } parse_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [WORD_W-1:0]  h;
    logic [WORD_W-1:0]  d;
    logic [LABEL_W-1:0] lab;
    logic [SCORE_W-1:0] sc;
    logic [LEN_W-1:0]   len;
    bit                 typed;
  } stim_t;

  logic clk = 0;
  logic rst_n;
  logic start, busy;
  logic [OP_W-1:0] in_operation;
  logic [WORD_W-1:0] in_head, in_dependent;
  logic [LABEL_W-1:0] in_label;
  logic signed [SCORE_W-1:0] in_score;
  logic [LEN_W-1:0] in_length;
  logic out_valid, out_last;
  logic [WORD_W-1:0] out_word;
  logic signed [HEAD_W-1:0] out_head_word;
  logic signed [WLABEL_W-1:0] out_word_label;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  projective_dependency_decoder_core dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  bit use_unl, use_lab, lab_out;
  int lab_count;
  longint unl_tab [MAX_WORDS*MAX_WORDS];
  bit     unl_set [MAX_WORDS*MAX_WORDS];
  longint lab_tab [MAX_WORDS*MAX_WORDS*MAX_LABELS];
  bit     lab_set [MAX_WORDS*MAX_WORDS*MAX_LABELS];
  longint whole_sc [MAX_WORDS*MAX_WORDS];
  bit     whole_ok [MAX_WORDS*MAX_WORDS];
  int     whole_cut [MAX_WORDS*MAX_WORDS];
  int     whole_lab [MAX_WORDS*MAX_WORDS];
  longint arc_sc [MAX_WORDS*MAX_WORDS*MAX_LABELS];
  bit     arc_ok [MAX_WORDS*MAX_WORDS*MAX_LABELS];
  int     arc_cut [MAX_WORDS*MAX_WORDS*MAX_LABELS];
  int fr_inc [STACK_DEPTH], fr_a [STACK_DEPTH], fr_b [STACK_DEPTH], fr_lab [STACK_DEPTH];
  int sp;
  int word_head [MAX_WORDS], word_lab [MAX_WORDS];

  parse_t parses_due [$];
  int errors = 0;
  int items = 0;
  int cycles = 0;

  function automatic int ci(int a, int b);
    return a * MAX_WORDS + b;
  endfunction

  function automatic int li(int a, int b, int l);
    return ci(a, b) * MAX_LABELS + l;
  endfunction

  function automatic void frame_push(int inc, int a, int b, int lab);
    if (a == b && inc == 0) return;
    if (sp >= STACK_DEPTH) return;
    fr_inc[sp] = inc;
    fr_a[sp] = a;
    fr_b[sp] = b;
    fr_lab[sp] = lab;
    sp++;
  endfunction

  function automatic void fill_spans(int n, int nl);
    int t, k;
    longint base, c;
    for (int w = 1; w < n; w++) begin
      for (int s = 0; s + w < n; s++) begin
        t = s + w;
        whole_ok[ci(s, t)] = 0;
        whole_ok[ci(t, s)] = 0;
        for (int l = 0; l < nl; l++) begin
          arc_ok[li(s, t, l)] = 0;
          arc_ok[li(t, s, l)] = 0;
        end
        for (int r = s; r < t; r++) begin
          if (!whole_ok[ci(s, r)] || !whole_ok[ci(t, r + 1)]) continue;
          base = whole_sc[ci(s, r)] + whole_sc[ci(t, r + 1)];
          for (int l = 0; l < nl; l++) begin
            c = base;
            k = li(s, t, l);
            if (use_unl) c += unl_tab[ci(s, t)];
            if (use_lab) c += lab_tab[k];
            if (!arc_ok[k] || c > arc_sc[k]) begin
              arc_ok[k] = 1; arc_sc[k] = c; arc_cut[k] = r;
            end
            if (s != 0) begin
              c = base;
              k = li(t, s, l);
              if (use_unl) c += unl_tab[ci(t, s)];
              if (use_lab) c += lab_tab[k];
              if (!arc_ok[k] || c > arc_sc[k]) begin
                arc_ok[k] = 1; arc_sc[k] = c; arc_cut[k] = r;
              end
            end
          end
        end
        for (int r = s; r <= t; r++) begin
          if (r != s && whole_ok[ci(r, t)]) begin
            k = ci(s, t);
            for (int l = 0; l < nl; l++) begin
              if (!arc_ok[li(s, r, l)]) continue;
              c = arc_sc[li(s, r, l)] + whole_sc[ci(r, t)];
              if (!whole_ok[k] || c > whole_sc[k]) begin
                whole_ok[k] = 1; whole_sc[k] = c; whole_cut[k] = r; whole_lab[k] = l;
              end
            end
          end
          if (r != t && s != 0 && whole_ok[ci(r, s)]) begin
            k = ci(t, s);
            for (int l = 0; l < nl; l++) begin
              if (!arc_ok[li(t, r, l)]) continue;
              c = whole_sc[ci(r, s)] + arc_sc[li(t, r, l)];
              if (!whole_ok[k] || c > whole_sc[k]) begin
                whole_ok[k] = 1; whole_sc[k] = c; whole_cut[k] = r; whole_lab[k] = l;
              end
            end
          end
        end
      end
    end
  endfunction

  function automatic void predict_parse(int len);
    int n, nl, a, b, r, inc, lab;
    parse_t p;
    n = len > MAX_WORDS ? MAX_WORDS : len;
    if (n == 0) return;
    nl = lab_count < 1 ? 1 : (lab_count > MAX_LABELS ? MAX_LABELS : lab_count);
    for (int k = 0; k < n; k++) begin
      whole_ok[ci(k, k)] = 1;
      whole_sc[ci(k, k)] = 0;
      word_head[k] = -1;
      word_lab[k] = -1;
    end
    fill_spans(n, nl);
    sp = 0;
    if (n >= 2 && whole_ok[ci(0, n - 1)]) frame_push(0, 0, n - 1, 0);
    while (sp > 0) begin
      sp--;
      inc = fr_inc[sp]; a = fr_a[sp]; b = fr_b[sp]; lab = fr_lab[sp];
      if (inc != 0) begin
        r = arc_cut[li(a, b, lab)];
        word_head[b] = a;
        word_lab[b] = lab;
        if (a < b) begin
          frame_push(0, a, r, 0); frame_push(0, b, r + 1, 0);
        end else begin
          frame_push(0, b, r, 0); frame_push(0, a, r + 1, 0);
        end
      end else begin
        r = whole_cut[ci(a, b)];
        frame_push(1, a, r, whole_lab[ci(a, b)]);
        frame_push(0, r, b, 0);
      end
    end
    for (int k = 0; k < n; k++) begin
      p.word = WORD_W'(k);
      p.head = HEAD_W'(word_head[k]);
      p.lab = WLABEL_W'(lab_out ? word_lab[k] : -1);
      p.last = (k == n - 1);
      parses_due.push_back(p);
    end
  endfunction

  // check results against the oldest expectation
  always @(posedge clk) begin
    parse_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (parses_due.size() == 0) begin
        $error("unexpected result word %0d", out_word);
        errors++;
      end else begin
        e = parses_due.pop_front();
        if (out_word !== e.word) begin
          $error("word: expected %0d, got %0d", e.word, out_word); errors++;
        end
        if (out_head_word !== e.head) begin
          $error("head_word: expected %0d, got %0d", e.head, out_head_word); errors++;
        end
        if (out_word_label !== e.lab) begin
          $error("word_label: expected %0d, got %0d", e.lab, out_word_label); errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] h,
                      input logic [WORD_W-1:0] d, input logic [LABEL_W-1:0] lab,
                      input logic [SCORE_W-1:0] sc, input logic [LEN_W-1:0] len,
                      input bit typed);
    parse_t p;
    start <= 1'b1;
    in_operation <= op;
    in_head <= h;
    in_dependent <= d;
    in_label <= lab;
    in_score <= sc;
    in_length <= len;
    do @(posedge clk); while (busy);
    if (op != OP_NONE) items++;
    case (op)
      OP_LOAD_UNL: begin
        unl_tab[ci(h, d)] = longint'($signed(sc));
        unl_set[ci(h, d)] = 1;
      end
      OP_LOAD_LAB: begin
        lab_tab[li(h, d, lab)] = longint'($signed(sc));
        lab_set[li(h, d, lab)] = 1;
      end
      OP_DECODE: begin
        if (typed) begin
          // root alone, or a two-word sentence with unlabeled output
          for (int k = 0; k < len; k++) begin
            p.word = WORD_W'(k);
            p.head = HEAD_W'((k == 0) ? -1 : 0);
            p.lab = WLABEL_W'(-1);
            p.last = (k == len - 1);
            parses_due.push_back(p);
          end
        end else begin
          predict_parse(len);
        end
      end
      default: ;
    endcase
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (parses_due.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_USE_UNL:   use_unl = v[0];
      REG_USE_LAB:   use_lab = v[0];
      REG_LAB_OUT:   lab_out = v[0];
      REG_LAB_COUNT: lab_count = v;
      default: ;
    endcase
  endtask

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3, 4, 5: return ($urandom_range(0, 4) - 2) << 16;
      default: return $urandom;
    endcase
  endfunction

  stim_t directed [20] = '{
    '{OP_DECODE,   0,  0,  0, 32'h0,        7'd0,   1},
    '{OP_DECODE,   63, 63, 15, 32'hffffffff, 7'd1,  1},
    '{OP_NONE,     63, 63, 15, 32'hffffffff, 7'd127, 0},
    '{OP_LOAD_UNL, 0,  1,  0, 32'h7fffffff, 7'd0,   0},
    '{OP_DECODE,   0,  0,  0, 32'h0,        7'd2,   1},
    '{OP_LOAD_UNL, 0,  1,  0, 32'h80000000, 7'd0,   0},
    '{OP_DECODE,   0,  0,  0, 32'h0,        7'd2,   1},
    '{OP_LOAD_UNL, 63, 63, 0, 32'h0,        7'd0,   0},
    '{OP_LOAD_UNL, 63, 0,  0, 32'hffffffff, 7'd0,   0},
    '{OP_LOAD_LAB, 63, 63, 15, 32'h80000000, 7'd0,  0},
    '{OP_LOAD_LAB, 0,  0,  0, 32'h7fffffff, 7'd0,   0},
    '{OP_LOAD_UNL, 0,  1,  0, 32'h00010000, 7'd0,   0},
    '{OP_LOAD_UNL, 0,  2,  0, 32'h00010000, 7'd0,   0},
    '{OP_LOAD_UNL, 1,  2,  0, 32'h00010000, 7'd0,   0},
    '{OP_LOAD_UNL, 2,  1,  0, 32'h00010000, 7'd0,   0},
    '{OP_DECODE,   0,  0,  0, 32'h0,        7'd3,   0},
    '{OP_LOAD_UNL, 0,  2,  0, 32'h80000000, 7'd0,   0},
    '{OP_LOAD_UNL, 1,  2,  0, 32'h80000000, 7'd0,   0},
    '{OP_LOAD_UNL, 2,  1,  0, 32'h7fffffff, 7'd0,   0},
    '{OP_DECODE,   0,  0,  0, 32'h0,        7'd3,   0}
  };

  initial begin
    int n, nl, s, t, sentences;
    bit gappy;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_NONE;
    in_head <= '0;
    in_dependent <= '0;
    in_label <= '0;
    in_score <= '0;
    in_length <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_USE_UNL;
    cfg_data <= '0;
    use_unl = 1; use_lab = 0; lab_out = 0; lab_count = 16;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send(directed[i].op, directed[i].h, directed[i].d, directed[i].lab,
           directed[i].sc, directed[i].len, directed[i].typed);

    // longest sentence with no scores in use, label count zero acting as one, then a count above MAX_LABELS
    drain();
    set_reg(REG_USE_UNL, 5'd0);
    set_reg(REG_USE_LAB, 5'd0);
    set_reg(REG_LAB_OUT, 5'd1);
    set_reg(REG_LAB_COUNT, 5'd0);
    send(OP_DECODE, 0, 0, 0, 0, 7'd127, 0);
    drain();
    set_reg(REG_LAB_COUNT, 5'd31);
    send(OP_DECODE, 0, 0, 0, 0, 7'd20, 0);

    while (items < 450) begin
      drain();
      set_reg(REG_USE_UNL, {4'($urandom_range(0, 15)), 1'($urandom_range(0, 3) != 0)});
      set_reg(REG_USE_LAB, {4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))});
      set_reg(REG_LAB_OUT, {4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))});
      case ($urandom_range(0, 5))
        0: set_reg(REG_LAB_COUNT, 5'd0);
        1: set_reg(REG_LAB_COUNT, 5'd1);
        2: set_reg(REG_LAB_COUNT, 5'd16);
        3: set_reg(REG_LAB_COUNT, 5'($urandom_range(17, 31)));
        default: set_reg(REG_LAB_COUNT, 5'($urandom_range(1, 16)));
      endcase
      nl = lab_count < 1 ? 1 : (lab_count > MAX_LABELS ? MAX_LABELS : lab_count);
      gappy = $urandom_range(0, 2) != 0;
      sentences = $urandom_range(1, 4);
      repeat (sentences) begin
        case ($urandom_range(0, 19))
          0: n = 0;
          1: n = 1;
          2: n = use_lab ? 6 : 10;
          default: n = $urandom_range(2, use_lab ? 5 : 8);
        endcase
        // fresh content within the sentence, plus loads elsewhere and noise
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 5))
            0: send(OP_NONE, WORD_W'($urandom), WORD_W'($urandom), LABEL_W'($urandom),
                    $urandom, LEN_W'($urandom), 0);
            1: send(OP_LOAD_LAB, WORD_W'($urandom), WORD_W'($urandom), LABEL_W'($urandom),
                    pick_score(), LEN_W'($urandom), 0);
            2: send(OP_LOAD_UNL, WORD_W'($urandom), WORD_W'($urandom), LABEL_W'($urandom),
                    pick_score(), LEN_W'($urandom), 0);
            default: begin
              s = $urandom_range(0, n > 1 ? n - 1 : 1);
              t = $urandom_range(0, n > 1 ? n - 1 : 1);
              send($urandom_range(0, 1) ? OP_LOAD_UNL : OP_LOAD_LAB, WORD_W'(s), WORD_W'(t),
                   LABEL_W'($urandom_range(0, nl - 1)), pick_score(), LEN_W'($urandom), 0);
            end
          endcase
          if (gappy && $urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
        end
        // write every score the decode will read that is not yet loaded
        for (int a = 0; a < n; a++) begin
          for (int b = a + 1; b < n; b++) begin
            if (use_unl && !unl_set[ci(a, b)])
              send(OP_LOAD_UNL, WORD_W'(a), WORD_W'(b), LABEL_W'($urandom), pick_score(),
                   LEN_W'($urandom), 0);
            if (use_unl && a != 0 && !unl_set[ci(b, a)])
              send(OP_LOAD_UNL, WORD_W'(b), WORD_W'(a), LABEL_W'($urandom), pick_score(),
                   LEN_W'($urandom), 0);
            for (int l = 0; l < nl; l++) begin
              if (use_lab && !lab_set[li(a, b, l)])
                send(OP_LOAD_LAB, WORD_W'(a), WORD_W'(b), LABEL_W'(l), pick_score(),
                     LEN_W'($urandom), 0);
              if (use_lab && a != 0 && !lab_set[li(b, a, l)])
                send(OP_LOAD_LAB, WORD_W'(b), WORD_W'(a), LABEL_W'(l), pick_score(),
                     LEN_W'($urandom), 0);
            end
          end
        end
        send(OP_DECODE, WORD_W'($urandom), WORD_W'($urandom), LABEL_W'($urandom), $urandom,
             LEN_W'(n), 0);
        if (gappy && $urandom_range(0, 1) == 0) pause($urandom_range(1, 40));
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pdd_pkg.sv
rtl/pdd_ram.sv
rtl/projective_dependency_decoder_core.sv
rtl/pdd_chk.sv
verif/tb.sv
